// ===== hw/rtl/arfl_pkg.sv =====
// shared types and constants of the address range free list
package arfl_pkg;

  localparam int MAX_RANGES = 16;
  localparam int IDX_W = $clog2(MAX_RANGES);
  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam int ADDR_W = 48;
  localparam int WIDE_W = 50;
  localparam int PAD_W = 37;

  localparam logic [ADDR_W-1:0] PAGE_BYTES = 48'd4096;
  localparam logic [ADDR_W-1:0] ALIGN_BYTES = 48'd2097152;
  localparam logic [ADDR_W-1:0] TOP_ADDRESS = 48'h8000_0000_0000;
  localparam logic [PAD_W-1:0] PAD_RESET = 37'h10_0000_0000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FREE  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] range_low;
    logic [ADDR_W-1:0] range_high;
    logic [ADDR_W-1:0] request_size;
    logic [ADDR_W-1:0] search_start;
    logic [ADDR_W-1:0] search_end;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] found_address;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic    load;
    logic    step;
    logic    cand;
    logic    commit;
    logic    res_we;
    status_e res_status;
  } cmd_t;

  typedef struct packed {
    logic is_find;
    logic at_end;
    logic inv;
    logic hit;
    logic full;
    logic skip;
    logic stop;
    logic fit;
  } sts_t;

endpackage

// ===== hw/rtl/arfl_datapath.sv =====
// range table, request registers and scan arithmetic
module arfl_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  arfl_pkg::cmd_t            cmd_i,
  output arfl_pkg::sts_t            sts_o,
  input  arfl_pkg::req_t            req_i,
  input  logic                      cfg_we_i,
  input  logic [arfl_pkg::PAD_W-1:0] cfg_data_i,
  output arfl_pkg::rsp_t            rsp_o
);

  localparam int AW = arfl_pkg::ADDR_W;
  localparam int WW = arfl_pkg::WIDE_W;
  localparam int N = arfl_pkg::MAX_RANGES;
  localparam logic [WW-1:0] ALIGN_M1 = WW'(arfl_pkg::ALIGN_BYTES) - WW'(1);

  logic [AW-1:0] lower_q [N];
  logic [AW-1:0] upper_q [N];
  logic [AW-1:0] lower_d [N];
  logic [AW-1:0] upper_d [N];
  logic [arfl_pkg::CNT_W-1:0] count_q, count_d;
  logic [arfl_pkg::CNT_W-1:0] idx_q;
  logic [arfl_pkg::IDX_W-1:0] idx;
  logic [arfl_pkg::PAD_W-1:0] pad_q;

  logic          find_q;
  logic [AW-1:0] lo_q, hi_q, size_q, end_q;
  logic [WW-1:0] start_q;
  logic [AW-1:0] c_lo_q, c_hi_q, c_re_q;
  logic [WW-1:0] c_al_q;
  logic [AW-1:0] found_q;
  logic [1:0]    status_q;

  logic [AW-1:0] rd_lo, rd_hi, re, pad_ext, end_d;
  logic [WW-1:0] rs, al, start_d;
  logic          keep_low, keep_high;

  assign idx = idx_q[arfl_pkg::IDX_W-1:0];
  assign rd_lo = lower_q[idx];
  assign rd_hi = upper_q[idx];
  assign pad_ext = AW'(pad_q);

  assign start_d = (req_i.search_start == '0) ? WW'(arfl_pkg::PAGE_BYTES)
                 : WW'(req_i.search_start) + WW'(pad_q);
  assign end_d = (req_i.search_end == '0) ? arfl_pkg::TOP_ADDRESS
               : (req_i.search_end >= pad_ext) ? req_i.search_end - pad_ext : '0;

  assign rs = (WW'(rd_lo) <= start_q) ? start_q : WW'(rd_lo);
  assign al = (rs + ALIGN_M1) & ~ALIGN_M1;
  assign re = (rd_lo <= end_q && end_q < rd_hi) ? end_q : rd_hi;

  assign keep_low = lo_q > rd_lo;
  assign keep_high = hi_q < rd_hi;

  assign sts_o.is_find = find_q;
  assign sts_o.at_end = idx_q >= count_q;
  assign sts_o.inv = lo_q > hi_q;
  assign sts_o.hit = (rd_hi > lo_q) && (hi_q > rd_lo);
  assign sts_o.full = keep_low && keep_high && (count_q >= arfl_pkg::CNT_W'(N));
  assign sts_o.skip = WW'(c_hi_q) <= start_q;
  assign sts_o.stop = c_lo_q > end_q;
  assign sts_o.fit = (WW'(c_lo_q) <= c_al_q) && (c_al_q < WW'(c_hi_q))
                   && (WW'(c_re_q) >= c_al_q)
                   && ((WW'(c_re_q) - c_al_q) >= WW'(size_q));

  assign rsp_o.found_address = found_q;
  assign rsp_o.status = status_q;

  // table update for one allocation
  always_comb begin
    for (int k = 0; k < N; k++) begin
      lower_d[k] = lower_q[k];
      upper_d[k] = upper_q[k];
    end
    count_d = count_q;
    if (keep_low && keep_high) begin
      for (int k = 1; k < N; k++) begin
        if (arfl_pkg::IDX_W'(k) > idx + arfl_pkg::IDX_W'(1) && arfl_pkg::IDX_W'(k) > idx) begin
          lower_d[k] = lower_q[k-1];
          upper_d[k] = upper_q[k-1];
        end
        if (arfl_pkg::IDX_W'(k-1) == idx) begin
          lower_d[k] = hi_q;
          upper_d[k] = rd_hi;
        end
      end
      lower_d[idx] = rd_lo;
      upper_d[idx] = lo_q;
      count_d = count_q + arfl_pkg::CNT_W'(1);
    end else if (keep_low) begin
      upper_d[idx] = lo_q;
    end else if (keep_high) begin
      lower_d[idx] = hi_q;
    end else begin
      for (int k = 0; k < N - 1; k++) begin
        if (arfl_pkg::IDX_W'(k) >= idx) begin
          lower_d[k] = lower_q[k+1];
          upper_d[k] = upper_q[k+1];
        end
      end
      count_d = count_q - arfl_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) begin
        lower_q[k] <= '0;
        upper_q[k] <= '0;
      end
      lower_q[0] <= arfl_pkg::PAGE_BYTES;
      upper_q[0] <= arfl_pkg::TOP_ADDRESS;
      count_q <= arfl_pkg::CNT_W'(1);
      idx_q <= '0;
      pad_q <= arfl_pkg::PAD_RESET;
    end else begin
      if (cfg_we_i) begin
        pad_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + arfl_pkg::CNT_W'(1);
      end
      if (cmd_i.commit) begin
        for (int k = 0; k < N; k++) begin
          lower_q[k] <= lower_d[k];
          upper_q[k] <= upper_d[k];
        end
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      find_q <= req_i.req_type;
      lo_q <= req_i.range_low;
      hi_q <= req_i.range_high;
      size_q <= req_i.request_size;
      start_q <= start_d;
      end_q <= end_d;
    end
    if (cmd_i.cand) begin
      c_lo_q <= rd_lo;
      c_hi_q <= rd_hi;
      c_al_q <= al;
      c_re_q <= re;
    end
    if (cmd_i.res_we) begin
      status_q <= cmd_i.res_status;
      found_q <= (find_q && cmd_i.res_status == arfl_pkg::ST_OK) ? c_al_q[AW-1:0] : '0;
    end
  end

endmodule

// ===== hw/rtl/arfl_controller.sv =====
// request sequencer for allocate and find scans
module arfl_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  arfl_pkg::sts_t sts_i,
  output arfl_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_ALLOC,
    S_FIND_RD,
    S_FIND_CHK,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_RESP);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.res_status = arfl_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = sts_i.is_find ? S_FIND_RD : S_ALLOC;
      end
      S_ALLOC: begin
        if (sts_i.inv || sts_i.at_end) begin
          cmd_o.res_we = 1'b1;
          cmd_o.res_status = arfl_pkg::ST_NOT_FREE;
          state_d = S_RESP;
        end else if (sts_i.hit) begin
          cmd_o.res_we = 1'b1;
          if (sts_i.full) begin
            cmd_o.res_status = arfl_pkg::ST_FULL;
          end else begin
            cmd_o.commit = 1'b1;
          end
          state_d = S_RESP;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_FIND_RD: begin
        if (sts_i.at_end) begin
          cmd_o.res_we = 1'b1;
          cmd_o.res_status = arfl_pkg::ST_NOT_FOUND;
          state_d = S_RESP;
        end else begin
          cmd_o.cand = 1'b1;
          state_d = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        if (sts_i.skip) begin
          cmd_o.step = 1'b1;
          state_d = S_FIND_RD;
        end else if (sts_i.stop) begin
          cmd_o.res_we = 1'b1;
          cmd_o.res_status = arfl_pkg::ST_NOT_FOUND;
          state_d = S_RESP;
        end else if (sts_i.fit) begin
          cmd_o.res_we = 1'b1;
          state_d = S_RESP;
        end else begin
          cmd_o.step = 1'b1;
          state_d = S_FIND_RD;
        end
      end
      S_RESP: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_commit_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (sts_i.hit && !sts_i.full && !sts_i.at_end && !sts_i.inv))
    else $error("table commit without a free overlapping range");
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_we |=> out_valid_o)
    else $error("result written but not presented");
  a_resp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.step && cmd_o.res_we))
    else $error("scan advanced while finishing");
`endif

endmodule

// ===== hw/rtl/address_range_free_list.sv =====
// top level of the address range free list
//
//   channel  direction  handshake          payload
//   in       input      in_valid_i/stall   arfl_pkg::req_t
//   out      output     out_valid_o/stall  arfl_pkg::rsp_t
//   cfg      input      cfg_valid_i/ready  pad_bytes, 37 bits
//
// allocate: after load and dispatch, S_ALLOC checks entries up to the first overlap or the end of the table
// find: after load and dispatch, each entry is read (S_FIND_RD) and checked (S_FIND_CHK) until a fit, a stop or the end
// the result is then presented in S_RESP, held while out_stall_i is high
// reset loads one range [4096, 2^47) and pad_bytes 2^36, no clearing pass
module address_range_free_list (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  arfl_pkg::req_t             in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output arfl_pkg::rsp_t             out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [arfl_pkg::PAD_W-1:0] cfg_data_i
);

  arfl_pkg::cmd_t cmd;
  arfl_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  arfl_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  arfl_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_i      (in_data_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (out_data_o)
  );

endmodule

// ===== verif/tb_top.sv =====
// testbench for the address range free list: scoreboard with a behavioral table model

class free_list_scoreboard;
  logic [arfl_pkg::ADDR_W-1:0] lower_q[arfl_pkg::MAX_RANGES];
  logic [arfl_pkg::ADDR_W-1:0] upper_q[arfl_pkg::MAX_RANGES];
  int unsigned count;
  logic [arfl_pkg::PAD_W-1:0] pad;
  arfl_pkg::rsp_t pending_q[$];
  int unsigned errors;

  function new();
    foreach (lower_q[k]) begin
      lower_q[k] = '0;
      upper_q[k] = '0;
    end
    lower_q[0] = arfl_pkg::PAGE_BYTES;
    upper_q[0] = arfl_pkg::TOP_ADDRESS;
    count = 1;
    pad = arfl_pkg::PAD_RESET;
    errors = 0;
  endfunction

  function void set_pad(logic [arfl_pkg::PAD_W-1:0] v);
    pad = v;
  endfunction

  function arfl_pkg::status_e allocate(logic [arfl_pkg::ADDR_W-1:0] lo,
                                       logic [arfl_pkg::ADDR_W-1:0] hi);
    int i;
    logic [arfl_pkg::ADDR_W-1:0] flo, fhi;
    bit keep_lo, keep_hi;
    if (lo > hi) return arfl_pkg::ST_NOT_FREE;
    for (i = 0; i < count; i++)
      if (upper_q[i] > lo && hi > lower_q[i]) break;
    if (i >= count) return arfl_pkg::ST_NOT_FREE;
    flo = lower_q[i];
    fhi = upper_q[i];
    keep_lo = lo > flo;
    keep_hi = hi < fhi;
    if (keep_lo && keep_hi && count >= arfl_pkg::MAX_RANGES) return arfl_pkg::ST_FULL;
    for (int k = i; k + 1 < count; k++) begin
      lower_q[k] = lower_q[k+1];
      upper_q[k] = upper_q[k+1];
    end
    count--;
    if (keep_hi) insert(i, hi, fhi);
    if (keep_lo) insert(i, flo, lo);
    return arfl_pkg::ST_OK;
  endfunction

  function void insert(int pos, logic [arfl_pkg::ADDR_W-1:0] lo,
                       logic [arfl_pkg::ADDR_W-1:0] hi);
    for (int k = count; k > pos; k--) begin
      lower_q[k] = lower_q[k-1];
      upper_q[k] = upper_q[k-1];
    end
    lower_q[pos] = lo;
    upper_q[pos] = hi;
    count++;
  endfunction

  function arfl_pkg::status_e find(logic [arfl_pkg::ADDR_W-1:0] size,
                                   logic [arfl_pkg::ADDR_W-1:0] s,
                                   logic [arfl_pkg::ADDR_W-1:0] e,
                                   output logic [arfl_pkg::ADDR_W-1:0] addr);
    logic [63:0] start, stop, lo, hi, rs, re, al;
    addr = '0;
    start = (s == '0) ? 64'(arfl_pkg::PAGE_BYTES) : 64'(s) + 64'(pad);
    if (e == '0) stop = 64'(arfl_pkg::TOP_ADDRESS);
    else stop = (64'(e) >= 64'(pad)) ? 64'(e) - 64'(pad) : 64'd0;
    for (int i = 0; i < count; i++) begin
      lo = 64'(lower_q[i]);
      hi = 64'(upper_q[i]);
      if (hi <= start) continue;
      if (lo > stop) break;
      rs = (lo <= start) ? start : lo;
      al = ((rs + 64'(arfl_pkg::ALIGN_BYTES) - 64'd1) / 64'(arfl_pkg::ALIGN_BYTES))
           * 64'(arfl_pkg::ALIGN_BYTES);
      re = (lo <= stop && stop < hi) ? stop : hi;
      if (!(lo <= al && al < hi)) continue;
      if (re < al) continue;
      if (re - al >= 64'(size)) begin
        addr = al[arfl_pkg::ADDR_W-1:0];
        return arfl_pkg::ST_OK;
      end
    end
    return arfl_pkg::ST_NOT_FOUND;
  endfunction

  function void note_request(arfl_pkg::req_t r);
    arfl_pkg::rsp_t x;
    logic [arfl_pkg::ADDR_W-1:0] a;
    if (!r.req_type) begin
      x.found_address = '0;
      x.status = allocate(r.range_low, r.range_high);
    end else begin
      x.status = find(r.request_size, r.search_start, r.search_end, a);
      x.found_address = a;
    end
    pending_q.push_back(x);
  endfunction

  function void check_response(arfl_pkg::rsp_t got);
    arfl_pkg::rsp_t want;
    if (pending_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected response addr=%h st=%0d",
                                 got.found_address, got.status);
      return;
    end
    want = pending_q.pop_front();
    if (got.found_address !== want.found_address || got.status !== want.status) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp addr=%h st=%0d, got addr=%h st=%0d",
                 want.found_address, want.status, got.found_address, got.status);
    end
  endfunction
endclass

module tb_top;
  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, cfg_valid_i, cfg_ready_o;
  arfl_pkg::req_t in_data_i;
  arfl_pkg::rsp_t out_data_o;
  logic [arfl_pkg::PAD_W-1:0] cfg_data_i;

  free_list_scoreboard board;
  int send_idle_pct, recv_stall_pct;
  bit hold_off;
  longint cycles;

  address_range_free_list dut (.*);

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // response side: check and random stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_response(out_data_o);
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [arfl_pkg::ADDR_W-1:0] rand_addr();
    logic [arfl_pkg::ADDR_W-1:0] a;
    case ($urandom_range(5))
      0: a = 48'({$urandom, $urandom});
      1: a = 48'(arfl_pkg::TOP_ADDRESS)
             - 48'($urandom_range(3)) * 48'(arfl_pkg::ALIGN_BYTES);
      2: a = 48'($urandom_range(64)) * 48'(arfl_pkg::ALIGN_BYTES)
             + 48'($urandom_range(2)) * 48'h1000;
      3: a = 48'($urandom_range(8192));
      4: a = 48'($urandom_range(1 << 20)) << 21;
      default: a = 48'($urandom_range(1 << 30)) << $urandom_range(17);
    endcase
    return a;
  endfunction

  // valid stays up after an accept until the next call decides to idle or send
  task automatic send(arfl_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(r);
  endtask

  task automatic alloc(logic [arfl_pkg::ADDR_W-1:0] lo, logic [arfl_pkg::ADDR_W-1:0] hi);
    arfl_pkg::req_t r;
    r = '0;
    r.range_low = lo;
    r.range_high = hi;
    r.request_size = rand_addr();
    send(r);
  endtask

  task automatic find(logic [arfl_pkg::ADDR_W-1:0] sz, logic [arfl_pkg::ADDR_W-1:0] s,
                      logic [arfl_pkg::ADDR_W-1:0] e);
    arfl_pkg::req_t r;
    r = '0;
    r.req_type = 1;
    r.request_size = sz;
    r.search_start = s;
    r.search_end = e;
    r.range_low = rand_addr();
    send(r);
  endtask

  task automatic drain_and_write(logic [arfl_pkg::PAD_W-1:0] v);
    in_valid_i <= 0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_pad(v);
    cfg_valid_i <= 0;
  endtask

  task automatic random_items(int n);
    logic [arfl_pkg::ADDR_W-1:0] a, b;
    for (int i = 0; i < n; i++) begin
      a = rand_addr();
      b = ($urandom_range(3) == 0) ? rand_addr() : a + 48'($urandom_range(1 << 24));
      if ($urandom_range(1)) alloc(a, b);
      else find($urandom_range(3) == 0 ? rand_addr() : 48'($urandom_range(1 << 23)),
                $urandom_range(2) == 0 ? 48'd0 : rand_addr(),
                $urandom_range(2) == 0 ? 48'd0 : rand_addr());
    end
  endtask

  initial begin
    board = new();
    cycles = 0;
    in_valid_i = 0;
    in_data_i = '0;
    out_stall_i = 0;
    cfg_valid_i = 0;
    cfg_data_i = '0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // directed
    find(48'h1000, 48'd0, 48'd0);
    find(48'hffff_ffff_ffff, 48'd0, 48'd0);
    find(48'd0, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff);
    find(48'h1000, 48'h1000, 48'h10);
    alloc(48'h5000, 48'h4000);
    alloc(48'd0, 48'h1000);
    alloc(48'h20_0000, 48'h20_0000);
    alloc(48'h40_0000, 48'h60_0000);
    alloc(48'h1f_0000, 48'h80_0000);
    alloc(48'h7fff_ffff_0000, 48'hffff_ffff_ffff);
    find(48'h20_0000, 48'd0, 48'd0);
    find(48'h1, 48'h1, 48'h7fff_0000_0000);
    drain_and_write('0);
    find(48'h10_0000, 48'h1001, 48'h50_0000);
    find(48'h1, 48'h80_0000, 48'h80_0001);
    drain_and_write({arfl_pkg::PAD_W{1'b1}});
    find(48'h1, 48'h1, 48'hffff_ffff_ffff);
    find(48'h1, 48'h1, 48'h1);
    for (int i = 0; i < 20; i++)
      alloc(48'h1000_0000 + 48'(i) * 48'h40_0000 + 48'h1000,
            48'h1000_0000 + 48'(i) * 48'h40_0000 + 48'h2000);

    drain_and_write(arfl_pkg::PAD_RESET);
    random_items(150);
    send_idle_pct = 88;
    random_items(150);
    send_idle_pct = 0;
    recv_stall_pct = 88;
    random_items(150);
    drain_and_write(37'($urandom_range(1 << 22)));
    send_idle_pct = 29;
    recv_stall_pct = 29;
    random_items(200);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      random_items(30);
    join
    drain_and_write('0);
    random_items(200);
    drain_and_write({arfl_pkg::PAD_W{1'b1}});
    random_items(130);

    in_valid_i <= 0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (board.errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
